[sv/tbdp_pkg.sv]
package tbdp_pkg;

    localparam int MAX_COLS   = 4096;
    localparam int BLOCK_SIZE = 256;
    localparam int ACT_WIDTH  = 16;
    localparam int MAX_BLOCKS = MAX_COLS / BLOCK_SIZE;
    localparam int BLK_CNT_W  = $clog2(MAX_BLOCKS);
    localparam int BYTES_PER_BLOCK = BLOCK_SIZE / 4;
    localparam int POS_W      = $clog2(BYTES_PER_BLOCK);

    // activation store banked four ways by address bits 6:5
    localparam int BANKS      = 4;
    localparam int BANK_DEPTH = MAX_COLS / BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int BLK_W   = 24;
    localparam int ROW_W   = 48;
    localparam int SCALE_W = 32;
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = 80;

    localparam logic [POS_W-1:0]     POS_LAST    = POS_W'(BYTES_PER_BLOCK - 1);
    localparam logic [BLK_CNT_W:0]   NBLK_MAX    = (BLK_CNT_W + 1)'(MAX_BLOCKS);
    localparam logic [16:0]          ROW_CNT_MAX = 17'd65536;

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SCALE  = 2'd1;
    localparam logic [1:0] OP_WEIGHT = 2'd2;

    // ternary weight codes
    localparam logic [1:0] W_NEG  = 2'd0;
    localparam logic [1:0] W_ZERO = 2'd1;
    localparam logic [1:0] W_POS  = 2'd2;
    localparam logic [1:0] W_TWO  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_BLOCKS = 2'd0;
    localparam logic [1:0] REG_TSCALE = 2'd1;
    localparam logic [1:0] REG_FIRST  = 2'd2;
    localparam logic [1:0] REG_END    = 2'd3;

    typedef struct packed {
        logic [4:0]                 blocks;
        logic signed [SCALE_W-1:0]  tscale;
        logic [15:0]                first_row;
        logic [16:0]                end_row;
        logic                       first_load;
    } tbdp_cfg_t;

    localparam tbdp_cfg_t CFG_RESET = '{
        blocks:     5'd1,
        tscale:     32'sd65536,
        first_row:  16'd0,
        end_row:    17'd65536,
        first_load: 1'b0
    };

    typedef logic [BANKS-1:0][ACT_WIDTH-1:0] tbdp_acts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_BLK_MUL,
        S_BLK_ADD,
        S_ROW_LO,
        S_ROW_HI,
        S_ROW_RND,
        S_ROW_EMIT
    } tbdp_state_t;

endpackage

[sv/tbdp_regs.sv]
module tbdp_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output tbdp_pkg::tbdp_cfg_t   cfg
);

    tbdp_pkg::tbdp_cfg_t cfg_reg;
    tbdp_pkg::tbdp_cfg_t cfg_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next            = cfg_reg;
        cfg_next.first_load = 1'b0;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                tbdp_pkg::REG_BLOCKS: cfg_next.blocks = pwdata[4:0];
                tbdp_pkg::REG_TSCALE: cfg_next.tscale = pwdata;
                tbdp_pkg::REG_FIRST:
                begin
                    cfg_next.first_row  = pwdata[15:0];
                    cfg_next.first_load = 1'b1;
                end
                tbdp_pkg::REG_END:    cfg_next.end_row = pwdata[16:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tbdp_pkg::REG_BLOCKS: prdata = 32'(cfg_reg.blocks);
            tbdp_pkg::REG_TSCALE: prdata = 32'(cfg_reg.tscale);
            tbdp_pkg::REG_FIRST:  prdata = 32'(cfg_reg.first_row);
            tbdp_pkg::REG_END:    prdata = 32'(cfg_reg.end_row);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tbdp_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/tbdp_act_mem.sv]
module tbdp_act_mem (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [1:0]                        wr_bank,
    input  logic [tbdp_pkg::BANK_AW-1:0]      wr_addr,
    input  logic [tbdp_pkg::ACT_WIDTH-1:0]    wr_data,
    input  logic                              rd_en,
    input  logic [tbdp_pkg::BANK_AW-1:0]      rd_addr,
    output tbdp_pkg::tbdp_acts_t              rd_data
);

    // one bank per weight code of a byte, all four read at the same row
    for (genvar b = 0; b < tbdp_pkg::BANKS; b++)
    begin : g_bank
        logic [tbdp_pkg::ACT_WIDTH-1:0] mem [tbdp_pkg::BANK_DEPTH];
        logic [tbdp_pkg::ACT_WIDTH-1:0] data_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                data_reg <= mem[rd_addr];
            end
        end

        assign rd_data[b] = data_reg;
    end

endmodule

[sv/tbdp_mul.sv]
module tbdp_mul (
    input  logic                            clk,
    input  logic [tbdp_pkg::MUL_A_W-1:0]    a,
    input  logic [tbdp_pkg::MUL_B_W-1:0]    b,
    output logic [tbdp_pkg::MUL_P_W-1:0]    p
);

    logic [tbdp_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= tbdp_pkg::MUL_P_W'(a) * tbdp_pkg::MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

[sv/tbdp_ctrl.sv]
module tbdp_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tbdp_pkg::tbdp_cfg_t               cfg,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [15:0]                       block_scale,
    input  logic [7:0]                        weight_byte,
    output logic                              rd_en,
    output logic [tbdp_pkg::BANK_AW-1:0]      rd_addr,
    input  tbdp_pkg::tbdp_acts_t              rd_data,
    output logic [tbdp_pkg::MUL_A_W-1:0]      mul_a,
    output logic [tbdp_pkg::MUL_B_W-1:0]      mul_b,
    input  logic [tbdp_pkg::MUL_P_W-1:0]      mul_p,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [47:0]                row_value,
    output logic [15:0]                       row_index,
    output logic                              saturated
);

    // four codes of one byte into the block sum, saturating at each step
    function automatic logic [tbdp_pkg::BLK_W:0] blk_accumulate(
        input logic signed [tbdp_pkg::BLK_W-1:0] acc_in,
        input logic [7:0]                        codes,
        input tbdp_pkg::tbdp_acts_t              acts
    );
        logic signed [tbdp_pkg::BLK_W-1:0] acc;
        logic signed [17:0]                a_ext;
        logic signed [17:0]                term;
        logic signed [25:0]                sum;
        logic                              sat;
        acc = acc_in;
        sat = 1'b0;
        for (int k = 0; k < tbdp_pkg::BANKS; k++)
        begin
            a_ext = 18'(signed'(acts[k]));
            case (codes[2*k +: 2])
                tbdp_pkg::W_NEG:  term = -a_ext;
                tbdp_pkg::W_ZERO: term = '0;
                tbdp_pkg::W_POS:  term = a_ext;
                default:          term = a_ext <<< 1;
            endcase
            sum = 26'(acc) + 26'(term);
            if (sum > 26'sd8388607)
            begin
                acc = 24'sh7FFFFF;
                sat = 1'b1;
            end
            else if (sum < -26'sd8388608)
            begin
                acc = 24'sh800000;
                sat = 1'b1;
            end
            else
            begin
                acc = sum[23:0];
            end
        end
        return {sat, acc};
    endfunction

    // half precision to signed q16.16, round half away from zero, saturating
    function automatic logic [32:0] half_to_q16(input logic [15:0] h);
        logic        neg;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [10:0] mv;
        logic [3:0]  sh;
        logic [32:0] q;
        logic [32:0] lim;
        logic        sat;
        logic [31:0] val;
        neg = h[15];
        e   = h[14:10];
        m   = h[9:0];
        mv  = {1'b1, m};
        sh  = 4'(5'd9 - e);
        lim = neg ? 33'h080000000 : 33'h07FFFFFFF;
        if (e == 5'd31)
        begin
            q = lim + 33'd1;
        end
        else if (e == 5'd0)
        begin
            q = 33'((11'(m) + 11'd128) >> 8);
        end
        else if (e >= 5'd9)
        begin
            q = 33'(mv) << (e - 5'd9);
        end
        else
        begin
            q = (33'(mv) + (33'd1 << (sh - 4'd1))) >> sh;
        end
        sat = q > lim;
        if (sat)
        begin
            q = lim;
        end
        val = neg ? -q[31:0] : q[31:0];
        return {sat, val};
    endfunction

    // magnitude product to signed 48 bits: drop 16 fraction bits, round, saturate
    function automatic logic [tbdp_pkg::ROW_W:0] round_sat(
        input logic [tbdp_pkg::PROD_W-1:0] prod,
        input logic                        neg
    );
        logic [tbdp_pkg::PROD_W-1:0] rs;
        logic [63:0]                 q;
        logic [47:0]                 lim;
        logic [47:0]                 mag_v;
        logic                        sat;
        rs    = prod + tbdp_pkg::PROD_W'(16'h8000);
        q     = rs[79:16];
        lim   = neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
        sat   = q > 64'(lim);
        mag_v = sat ? lim : q[47:0];
        return {sat, (neg ? -mag_v : mag_v)};
    endfunction

    tbdp_pkg::tbdp_state_t state_reg, state_next;

    logic [tbdp_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [tbdp_pkg::BLK_CNT_W-1:0]     blk_cnt_reg, blk_cnt_next;
    logic [16:0]                        row_cnt_reg, row_cnt_next;
    logic signed [tbdp_pkg::BLK_W-1:0]  blk_acc_reg, blk_acc_next;
    logic signed [tbdp_pkg::ROW_W-1:0]  row_acc_reg, row_acc_next;
    logic signed [tbdp_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic                               row_sat_reg, row_sat_next;
    logic                               b_valid_reg, b_valid_next;
    logic [7:0]                         b_byte_reg, b_byte_next;
    logic [tbdp_pkg::MUL_P_W-1:0]       lo_prod_reg, lo_prod_next;
    logic signed [tbdp_pkg::ROW_W-1:0]  res_reg, res_next;
    logic                               res_sat_reg, res_sat_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [tbdp_pkg::ROW_W-1:0]  out_value_reg, out_value_next;
    logic [15:0]                        out_index_reg, out_index_next;
    logic                               out_sat_reg, out_sat_next;

    logic                               accept;
    logic                               out_free;
    logic [tbdp_pkg::BLK_W:0]           acc_res;
    logic [32:0]                        conv_res;
    logic [tbdp_pkg::MUL_A_W-1:0]       blk_mag;
    logic [tbdp_pkg::MUL_B_W-1:0]       scale_mag;
    logic [tbdp_pkg::ROW_W-1:0]         row_mag;
    logic [tbdp_pkg::MUL_B_W-1:0]       tscale_mag;
    logic [tbdp_pkg::ROW_W:0]           blk_prod_res;
    logic [tbdp_pkg::ROW_W:0]           row_prod_res;
    logic signed [tbdp_pkg::ROW_W:0]    row_sum;
    logic                               row_ovf;
    logic [tbdp_pkg::BLK_CNT_W:0]       nblk;

    assign in_stall = (state_reg != tbdp_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_addr  = {blk_cnt_reg, pos_reg};

    assign acc_res    = blk_accumulate(blk_acc_reg, b_byte_reg, rd_data);
    assign conv_res   = half_to_q16(block_scale);
    assign blk_mag    = blk_acc_reg[23] ? 24'(-blk_acc_reg) : 24'(blk_acc_reg);
    assign scale_mag  = scale_reg[31] ? 32'(-scale_reg) : 32'(scale_reg);
    assign row_mag    = row_acc_reg[47] ? 48'(-row_acc_reg) : 48'(row_acc_reg);
    assign tscale_mag = cfg.tscale[31] ? 32'(-cfg.tscale) : 32'(cfg.tscale);

    assign blk_prod_res = round_sat(tbdp_pkg::PROD_W'(mul_p), blk_acc_reg[23] ^ scale_reg[31]);
    // high partial product arrives the cycle after the low one, which is held in lo_prod_reg
    assign row_prod_res = round_sat(tbdp_pkg::PROD_W'(lo_prod_reg) + {mul_p, 24'b0},
                                    row_acc_reg[47] ^ cfg.tscale[31]);

    assign row_sum = 49'(row_acc_reg) + 49'(signed'(blk_prod_res[47:0]));
    assign row_ovf = row_sum[48] != row_sum[47];

    assign nblk = (cfg.blocks == 5'd0) ? 5'd1 :
                  (cfg.blocks > tbdp_pkg::NBLK_MAX) ? tbdp_pkg::NBLK_MAX : cfg.blocks;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        blk_cnt_next   = blk_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        blk_acc_next   = blk_acc_reg;
        row_acc_next   = row_acc_reg;
        scale_next     = scale_reg;
        row_sat_next   = row_sat_reg;
        b_valid_next   = 1'b0;
        b_byte_next    = b_byte_reg;
        lo_prod_next   = lo_prod_reg;
        res_next       = res_reg;
        res_sat_next   = res_sat_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_sat_next   = out_sat_reg;
        rd_en          = 1'b0;
        mul_a          = blk_mag;
        mul_b          = scale_mag;

        // second stage of a weight byte: activations are back from the store
        if (b_valid_reg)
        begin
            blk_acc_next = acc_res[23:0];
            row_sat_next = row_sat_reg | acc_res[24];
        end

        unique case (state_reg)
            tbdp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        tbdp_pkg::OP_SCALE:
                        begin
                            scale_next   = conv_res[31:0];
                            row_sat_next = row_sat_next | conv_res[32];
                            blk_acc_next = '0;
                            pos_next     = '0;
                        end
                        tbdp_pkg::OP_WEIGHT:
                        begin
                            rd_en        = 1'b1;
                            b_valid_next = 1'b1;
                            b_byte_next  = weight_byte;
                            pos_next     = pos_reg + 1'b1;
                            if (pos_reg == tbdp_pkg::POS_LAST)
                            begin
                                state_next = tbdp_pkg::S_LAST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tbdp_pkg::S_LAST:
            begin
                state_next = tbdp_pkg::S_BLK_MUL;
            end
            tbdp_pkg::S_BLK_MUL:
            begin
                state_next = tbdp_pkg::S_BLK_ADD;
            end
            tbdp_pkg::S_BLK_ADD:
            begin
                if (row_ovf)
                begin
                    row_acc_next = row_sum[48] ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
                end
                else
                begin
                    row_acc_next = row_sum[47:0];
                end
                row_sat_next = row_sat_reg | blk_prod_res[48] | row_ovf;
                blk_acc_next = '0;
                if (({1'b0, blk_cnt_reg} + 1'b1) < nblk)
                begin
                    blk_cnt_next = blk_cnt_reg + 1'b1;
                    state_next   = tbdp_pkg::S_IDLE;
                end
                else
                begin
                    blk_cnt_next = '0;
                    state_next   = tbdp_pkg::S_ROW_LO;
                end
            end
            tbdp_pkg::S_ROW_LO:
            begin
                mul_a      = row_mag[23:0];
                mul_b      = tscale_mag;
                state_next = tbdp_pkg::S_ROW_HI;
            end
            tbdp_pkg::S_ROW_HI:
            begin
                mul_a        = row_mag[47:24];
                mul_b        = tscale_mag;
                lo_prod_next = mul_p;
                state_next   = tbdp_pkg::S_ROW_RND;
            end
            tbdp_pkg::S_ROW_RND:
            begin
                res_next     = row_prod_res[47:0];
                res_sat_next = row_sat_reg | row_prod_res[48];
                state_next   = tbdp_pkg::S_ROW_EMIT;
            end
            tbdp_pkg::S_ROW_EMIT:
            begin
                if (out_free)
                begin
                    // rows at or past end_row are computed and dropped
                    if (row_cnt_reg < cfg.end_row)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = res_reg;
                        out_index_next = row_cnt_reg[15:0];
                        out_sat_next   = res_sat_reg;
                    end
                    if (row_cnt_reg < tbdp_pkg::ROW_CNT_MAX)
                    begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                    row_acc_next = '0;
                    row_sat_next = 1'b0;
                    state_next   = tbdp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tbdp_pkg::S_IDLE;
            end
        endcase

        if (cfg.first_load)
        begin
            row_cnt_next = {1'b0, cfg.first_row};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbdp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            blk_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            blk_acc_reg   <= '0;
            row_acc_reg   <= '0;
            scale_reg     <= '0;
            row_sat_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            blk_cnt_reg   <= blk_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            blk_acc_reg   <= blk_acc_next;
            row_acc_reg   <= row_acc_next;
            scale_reg     <= scale_next;
            row_sat_reg   <= row_sat_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_byte_reg    <= b_byte_next;
        lo_prod_reg   <= lo_prod_next;
        res_reg       <= res_next;
        res_sat_reg   <= res_sat_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_sat_reg   <= out_sat_next;
    end

    assign out_valid = out_valid_reg;
    assign row_value = out_value_reg;
    assign row_index = out_index_reg;
    assign saturated = out_sat_reg;

endmodule

[sv/ternary_block_dot_product.sv]
// loads, scale beats and weight bytes inside a block: one beat per cycle
// last weight byte of a block: input stalls to accumulate, multiply and add into row
// last byte of a row: also stalls for row product, round, emit; result then registered;
//   the shared 24x32 multiplier takes the row product as two partial products
// reset clears counters, accumulators, block scale and the output valid flag;
//   activation store is not cleared and holds garbage until loaded
module ternary_block_dot_product (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [11:0]         act_index,
    input  logic signed [15:0]  act_value,
    input  logic [15:0]         block_scale,
    input  logic [7:0]          weight_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [47:0]  row_value,
    output logic [15:0]         row_index,
    output logic                saturated
);

    tbdp_pkg::tbdp_cfg_t               cfg;
    tbdp_pkg::tbdp_acts_t              rd_data;
    logic                              accept;
    logic                              mem_wr_en;
    logic                              mem_rd_en;
    logic [tbdp_pkg::BANK_AW-1:0]      mem_rd_addr;
    logic [tbdp_pkg::MUL_A_W-1:0]      mul_a;
    logic [tbdp_pkg::MUL_B_W-1:0]      mul_b;
    logic [tbdp_pkg::MUL_P_W-1:0]      mul_p;

    assign accept    = in_valid && !in_stall;
    assign mem_wr_en = accept && (operation == tbdp_pkg::OP_LOAD);

    tbdp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // bank from bits 6:5, row from the remaining bits
    tbdp_act_mem u_act_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_bank (act_index[6:5]),
        .wr_addr ({act_index[11:7], act_index[4:0]}),
        .wr_data (act_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data)
    );

    tbdp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    tbdp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .block_scale (block_scale),
        .weight_byte (weight_byte),
        .rd_en       (mem_rd_en),
        .rd_addr     (mem_rd_addr),
        .rd_data     (rd_data),
        .mul_a       (mul_a),
        .mul_b       (mul_b),
        .mul_p       (mul_p),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_value   (row_value),
        .row_index   (row_index),
        .saturated   (saturated)
    );

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("activation store written and read in the same cycle");

    a_rd_only_on_weight: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (accept && (operation == tbdp_pkg::OP_WEIGHT)))
        else $error("activation read without an accepted weight byte");

    a_result_after_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced outside the row end sequence");

    a_wr_only_when_open: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> !in_stall)
        else $error("activation load taken while input stalled");

endmodule
